>>> rtl/bpop_pkg.sv
// Shared constants, codes and types of the branch prediction outcome profiler.
package bpop_pkg;

    // Default configuration
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int NUM_CLASSES_DEF = 6;
    localparam int NUM_KINDS_DEF   = 3;

    // Fixed field widths
    localparam int ADDR_W = 64;
    localparam int LEN_W  = 4;
    localparam int CLS_W  = 3;
    localparam int KIND_W = 2;
    localparam int SEL_W  = 3;
    localparam int RES_W  = 2;
    localparam int READ_W = 32;

    // Result buffer depth (covers the word in flight plus a stalled sink)
    localparam int RSP_DEPTH = 3;

    typedef logic [ADDR_W-1:0] t_addr;

    // Operation codes
    localparam logic OP_RETIRE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Instruction class that is not a branch
    localparam logic [CLS_W-1:0] CLS_NONBRANCH = 3'd0;

    // Resolution codes
    localparam logic [RES_W-1:0] RES_NONE      = 2'd0;
    localparam logic [RES_W-1:0] RES_HIT       = 2'd1;
    localparam logic [RES_W-1:0] RES_DIR_MISS  = 2'd2;
    localparam logic [RES_W-1:0] RES_ADDR_MISS = 2'd3;

    // Counter select codes
    localparam logic [SEL_W-1:0] SEL_COUNT     = 3'd0;
    localparam logic [SEL_W-1:0] SEL_HITS      = 3'd1;
    localparam logic [SEL_W-1:0] SEL_DIR_MISS  = 3'd2;
    localparam logic [SEL_W-1:0] SEL_ADDR_MISS = 3'd3;
    localparam logic [SEL_W-1:0] SEL_TOT_INST  = 3'd4;
    localparam logic [SEL_W-1:0] SEL_TOT_BR    = 3'd5;
    localparam logic [SEL_W-1:0] SEL_TOT_MISS  = 3'd6;

    // Word held in the update stage
    typedef struct packed {
        logic             op;
        t_addr            ip;
        logic [LEN_W-1:0] len;
        logic             is_br;   // retire of an in-range branch
        logic             cnt_we;  // retire that bumps a count entry
        logic             sel_ok;  // read selector class/kind in range
        logic             taken;
        t_addr            target;
        logic [SEL_W-1:0] sel;
    } t_s1_item;

endpackage

>>> rtl/bpop_if.sv
// Request and response channel interfaces of the branch prediction outcome profiler.
interface bpop_req_if;
    import bpop_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    t_addr             ip;
    logic [LEN_W-1:0]  inst_length;
    logic [CLS_W-1:0]  inst_class;
    logic [KIND_W-1:0] branch_kind;
    logic              pred_taken;
    t_addr             pred_target;
    logic [SEL_W-1:0]  counter_select;

    modport source (
        output valid, operation, ip, inst_length, inst_class, branch_kind,
               pred_taken, pred_target, counter_select,
        input  ready
    );
    modport sink (
        input  valid, operation, ip, inst_length, inst_class, branch_kind,
               pred_taken, pred_target, counter_select,
        output ready
    );
endinterface

interface bpop_rsp_if;
    import bpop_pkg::*;

    logic              valid;
    logic              ready;
    logic [RES_W-1:0]  resolution;
    logic [READ_W-1:0] read_value;

    modport source (output valid, resolution, read_value, input ready);
    modport sink   (input  valid, resolution, read_value, output ready);
endinterface

>>> rtl/bpop_cnt_mem.sv
// Counter memory: one write and one registered read per cycle, zero until written.
module bpop_cnt_mem #(
    parameter int DATA_W = bpop_pkg::COUNT_WIDTH_DEF,
    parameter int ROWS   = bpop_pkg::NUM_CLASSES_DEF * bpop_pkg::NUM_KINDS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [$clog2(ROWS)-1:0] i_rd_addr,
    input  logic                    i_wr_en,
    input  logic [$clog2(ROWS)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]       i_wr_data,
    output logic [DATA_W-1:0]       o_rd_data
);
    localparam int AW = $clog2(ROWS);

    logic [DATA_W-1:0] r_mem [ROWS];
    logic [DATA_W-1:0] r_rd_data;
    logic [AW-1:0]     r_rd_addr;
    logic [ROWS-1:0]   r_vld;
    logic              r_fwd_v;
    logic [AW-1:0]     r_fwd_addr;
    logic [DATA_W-1:0] r_fwd_data;

    // Storage array, read-first
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // Last write, for a read issued on the same edge
    always_ff @(posedge i_clk) begin
        r_fwd_addr <= i_wr_addr;
        r_fwd_data <= i_wr_data;
    end

    // Written-row flags and forward valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_fwd_v <= 1'b0;
        end else begin
            r_fwd_v <= i_wr_en;
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    // Read word: forwarded write, else stored value, else reset zero
    always_comb begin
        if (r_fwd_v && (r_fwd_addr == r_rd_addr)) begin
            o_rd_data = r_fwd_data;
        end else if (r_vld[r_rd_addr]) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

>>> rtl/branch_prediction_outcome_profiler_core.sv
// Top level of the branch prediction outcome profiler.
// Takes one word per clock while ready is high: a retired instruction or a
// counter read. A word is accepted on the cycle its counter rows are read from
// two single-port-read memories (per class/kind row: the instruction count in
// one, the hit / direction-miss / address-miss triple in the other); the next
// cycle resolves the previous branch, updates both rows and the three totals,
// and writes back, with the last write forwarded to a read on the same edge.
// The result word is registered into the result buffer at the end of the
// update stage and is offered on the response channel from there. A three-word
// result buffer keeps ready high while the sink takes words; ready drops when the
// buffered words plus the word in the update stage reach three. Row flags clear
// on reset, so the block accepts words as soon as reset is released.
module branch_prediction_outcome_profiler_core #(
    parameter int COUNT_WIDTH = bpop_pkg::COUNT_WIDTH_DEF,
    parameter int NUM_CLASSES = bpop_pkg::NUM_CLASSES_DEF,
    parameter int NUM_KINDS   = bpop_pkg::NUM_KINDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpop_req_if.sink   i_req,
    bpop_rsp_if.source o_rsp
);
    import bpop_pkg::*;

    localparam int CW    = COUNT_WIDTH;
    localparam int ROWS  = NUM_CLASSES * NUM_KINDS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int PTR_W = $clog2(RSP_DEPTH);
    localparam int CNT_W = $clog2(RSP_DEPTH + 1);

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        sat_inc = (c == {CW{1'b1}}) ? c : c + CW'(1);
    endfunction

    // Accept side
    logic             in_acc;
    logic             in_rng;
    logic             in_is_rd;
    logic             in_is_nb;
    logic [ROW_W-1:0] in_row;
    logic [ROW_W-1:0] cnt_rd_addr;
    logic [ROW_W-1:0] out_rd_addr;
    t_s1_item         n_s1;

    // Update stage
    logic             r_s1_v;
    t_s1_item         r_s1;
    logic [ROW_W-1:0] r_s1_cnt_row;
    logic [ROW_W-1:0] r_s1_out_row;

    // Branch tracking state and totals
    logic             r_last_br,   n_last_br;
    logic [ROW_W-1:0] r_last_row,  n_last_row;
    logic             r_last_taken, n_last_taken;
    t_addr            r_ft,        n_ft;
    t_addr            r_exp,       n_exp;
    logic [CW-1:0]    r_tot_inst,  n_tot_inst;
    logic [CW-1:0]    r_tot_br,    n_tot_br;
    logic [CW-1:0]    r_tot_miss,  n_tot_miss;

    // Memory data
    logic [CW-1:0]    cnt_q;
    logic [3*CW-1:0]  out_q;
    logic             cnt_we;
    logic [CW-1:0]    cnt_wd;
    logic             out_we;
    logic [3*CW-1:0]  out_wd;

    // Stage results
    logic             s1_ret;
    t_addr            ft_new;
    logic             dir_miss;
    logic [RES_W-1:0] n_res;
    logic [CW-1:0]    rd_cnt;
    logic [READ_W-1:0] rsp_val;

    // Result buffer
    logic [RES_W-1:0]  r_fifo_res [RSP_DEPTH];
    logic [READ_W-1:0] r_fifo_val [RSP_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_fifo_cnt;
    logic              pop;

    // ---------------- accept: decode and issue memory reads ----------------
    assign in_acc   = i_req.valid && i_req.ready;
    assign in_is_rd = (i_req.operation == OP_READ);
    assign in_is_nb = (i_req.inst_class == CLS_NONBRANCH);
    assign in_rng   = (int'(i_req.inst_class) < NUM_CLASSES) &&
                      (int'(i_req.branch_kind) < NUM_KINDS);
    assign in_row   = in_rng ? ROW_W'(int'(i_req.inst_class) * NUM_KINDS +
                                      int'(i_req.branch_kind)) : '0;

    // A non-branch always counts in the class 0 / direct row
    assign cnt_rd_addr = (!in_is_rd && in_is_nb) ? '0 : in_row;
    // Retire reads the row of the branch in flight (last state after stage 1)
    assign out_rd_addr = in_is_rd ? in_row : n_last_row;

    always_comb begin
        n_s1.op     = i_req.operation;
        n_s1.ip     = i_req.ip;
        n_s1.len    = i_req.inst_length;
        n_s1.is_br  = !in_is_rd && !in_is_nb && in_rng;
        n_s1.cnt_we = !in_is_rd && (in_is_nb || in_rng);
        n_s1.sel_ok = in_rng;
        n_s1.taken  = i_req.pred_taken;
        n_s1.target = i_req.pred_target;
        n_s1.sel    = i_req.counter_select;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1         <= n_s1;
            r_s1_cnt_row <= cnt_rd_addr;
            r_s1_out_row <= out_rd_addr;
        end
    end

    // ---------------- counter memories ----------------
    bpop_cnt_mem #(
        .DATA_W (CW),
        .ROWS   (ROWS)
    ) u_cnt_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (cnt_rd_addr),
        .i_wr_en   (cnt_we),
        .i_wr_addr (r_s1_cnt_row),
        .i_wr_data (cnt_wd),
        .o_rd_data (cnt_q)
    );

    bpop_cnt_mem #(
        .DATA_W (3 * CW),
        .ROWS   (ROWS)
    ) u_out_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (out_rd_addr),
        .i_wr_en   (out_we),
        .i_wr_addr (r_s1_out_row),
        .i_wr_data (out_wd),
        .o_rd_data (out_q)
    );

    // ---------------- update stage: resolve, count, write back ----------------
    assign s1_ret   = r_s1_v && (r_s1.op == OP_RETIRE);
    assign ft_new   = r_s1.ip + ADDR_W'(r_s1.len);
    assign dir_miss = (r_s1.ip != r_ft) ? !r_last_taken : r_last_taken;

    always_comb begin
        n_res        = RES_NONE;
        out_we       = 1'b0;
        out_wd       = out_q;
        cnt_we       = 1'b0;
        cnt_wd       = sat_inc(cnt_q);
        n_last_br    = r_last_br;
        n_last_row   = r_last_row;
        n_last_taken = r_last_taken;
        n_ft         = r_ft;
        n_exp        = r_exp;
        n_tot_inst   = r_tot_inst;
        n_tot_br     = r_tot_br;
        n_tot_miss   = r_tot_miss;
        if (s1_ret) begin
            n_tot_inst = sat_inc(r_tot_inst);
            // resolve the branch remembered from the previous retire
            if (r_last_br) begin
                out_we = 1'b1;
                if (r_s1.ip == r_exp) begin
                    n_res            = RES_HIT;
                    out_wd[CW-1:0]   = sat_inc(out_q[CW-1:0]);
                end else begin
                    n_tot_miss = sat_inc(r_tot_miss);
                    if (dir_miss) begin
                        n_res               = RES_DIR_MISS;
                        out_wd[2*CW-1:CW]   = sat_inc(out_q[2*CW-1:CW]);
                    end else begin
                        n_res               = RES_ADDR_MISS;
                        out_wd[3*CW-1:2*CW] = sat_inc(out_q[3*CW-1:2*CW]);
                    end
                end
            end
            // count this instruction and remember its prediction
            n_ft      = ft_new;
            n_last_br = r_s1.is_br;
            cnt_we    = r_s1.cnt_we;
            if (r_s1.is_br) begin
                n_last_row   = r_s1_cnt_row;
                n_last_taken = r_s1.taken;
                n_tot_br     = sat_inc(r_tot_br);
                n_exp        = r_s1.taken ? r_s1.target : ft_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_br    <= 1'b0;
            r_last_row   <= '0;
            r_last_taken <= 1'b0;
            r_ft         <= '0;
            r_exp        <= '0;
            r_tot_inst   <= '0;
            r_tot_br     <= '0;
            r_tot_miss   <= '0;
        end else begin
            r_last_br    <= n_last_br;
            r_last_row   <= n_last_row;
            r_last_taken <= n_last_taken;
            r_ft         <= n_ft;
            r_exp        <= n_exp;
            r_tot_inst   <= n_tot_inst;
            r_tot_br     <= n_tot_br;
            r_tot_miss   <= n_tot_miss;
        end
    end

    // Counter read select
    always_comb begin
        case (r_s1.sel)
            SEL_COUNT:     rd_cnt = r_s1.sel_ok ? cnt_q : '0;
            SEL_HITS:      rd_cnt = r_s1.sel_ok ? out_q[CW-1:0] : '0;
            SEL_DIR_MISS:  rd_cnt = r_s1.sel_ok ? out_q[2*CW-1:CW] : '0;
            SEL_ADDR_MISS: rd_cnt = r_s1.sel_ok ? out_q[3*CW-1:2*CW] : '0;
            SEL_TOT_INST:  rd_cnt = r_tot_inst;
            SEL_TOT_BR:    rd_cnt = r_tot_br;
            SEL_TOT_MISS:  rd_cnt = r_tot_miss;
            default:       rd_cnt = '0;
        endcase
    end

    assign rsp_val = (r_s1.op == OP_READ) ? READ_W'(rd_cnt) : '0;

    // ---------------- result buffer ----------------
    assign pop         = o_rsp.valid && o_rsp.ready;
    assign o_rsp.valid = (r_fifo_cnt != '0);
    assign o_rsp.resolution = r_fifo_res[r_rd_ptr];
    assign o_rsp.read_value = r_fifo_val[r_rd_ptr];
    assign i_req.ready = (int'(r_fifo_cnt) + int'(r_s1_v)) < RSP_DEPTH;

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_fifo_res[r_wr_ptr] <= n_res;
            r_fifo_val[r_wr_ptr] <= rsp_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (r_s1_v) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(RSP_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(RSP_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + CNT_W'(r_s1_v) - CNT_W'(pop);
        end
    end

    // ---------------- assertions ----------------
    // the result buffer always has room for the word leaving the update stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> (r_fifo_cnt < CNT_W'(RSP_DEPTH)) || pop)
        else $error("result buffer overflow");

    // a counter read leaves the totals untouched
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && (r_s1.op == OP_READ)) |=> $stable(r_tot_inst) && $stable(r_tot_miss)
                                             && $stable(r_tot_br))
        else $error("read word changed totals");

    // no resolution without a remembered branch
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !r_last_br) |-> (n_res == RES_NONE))
        else $error("resolution without pending branch");

    // branches and misses never outnumber retired instructions
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tot_br <= r_tot_inst) && (r_tot_miss <= r_tot_inst))
        else $error("totals out of order");

endmodule
